FILE: hdl/ucud_pkg.sv
// shared types and constants for the code unit decoder
`default_nettype none
package ucud_pkg;

    localparam int UnitW  = 16;
    localparam int CodeW  = 21;
    localparam int CountW = 3;

    localparam logic [1:0] MODE_LATIN1 = 2'd0;
    localparam logic [1:0] MODE_UTF16  = 2'd1;
    localparam logic [1:0] MODE_UTF8   = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_UTF8;

    localparam logic [CodeW-1:0] CODE_MAX      = 21'h10FFFF;
    localparam logic [CodeW-1:0] SUPPLEMENTARY = 21'h010000;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_CUT       = 2'd2
    } status_t;

    typedef struct packed {
        logic [CodeW-1:0]  code_point;
        status_t           status;
        logic [CountW-1:0] units_examined;
        logic              units_kept;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/ucud_in_reg.sv
// input register: holds one code unit beat until the decoder takes it
`default_nettype none
module ucud_in_reg
    import ucud_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [UnitW-1:0] code_unit,
    input  wire logic             advance,
    output logic                  unit_valid,
    output logic [UnitW-1:0]      unit_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [UnitW-1:0] unit_reg;
    logic             accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unit_reg <= code_unit;
        end
    end

    assign unit_valid = valid_reg;
    assign unit_data  = unit_reg;

endmodule
`default_nettype wire

FILE: hdl/ucud_decoder.sv
// sequence state and single-pass decode of one code unit
`default_nettype none
module ucud_decoder
    import ucud_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_mode,
    input  wire logic             step,
    input  wire logic [UnitW-1:0] unit,
    output logic                  res_fire,
    output result_t               res
);

    logic [1:0]        mode_reg;
    logic [CodeW-1:0]  partial_reg,   partial_next;
    logic [1:0]        remain_reg,    remain_next;
    logic [CountW-1:0] seen_reg,      seen_next;
    logic [CountW-1:0] len_reg,       len_next;
    logic              cfail_reg,     cfail_next;

    logic [7:0]        b;
    logic              is_low;
    logic              is_high;
    logic [CodeW-1:0]  shifted;
    logic [CodeW-1:0]  pair_code;
    logic [CodeW-1:0]  minimum;
    logic              fire;
    logic [CodeW-1:0]  cp;
    status_t           st;
    logic [CountW-1:0] n;
    logic              kept;

    assign b         = unit[7:0];
    assign is_low    = unit inside {[16'hDC00:16'hDFFF]};
    assign is_high   = unit inside {[16'hD800:16'hDBFF]};
    assign shifted   = {partial_reg[CodeW-7:0], b[5:0]};
    assign pair_code = SUPPLEMENTARY + {1'b0, partial_reg[9:0], unit[9:0]};

    always_comb
    begin
        case (len_reg)
            3'd2:    minimum = 21'h000080;
            3'd3:    minimum = 21'h000800;
            default: minimum = 21'h010000;
        endcase
    end

    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        seen_next    = seen_reg;
        len_next     = len_reg;
        cfail_next   = cfail_reg;
        fire         = 1'b0;
        cp           = '0;
        st           = ST_VALID;
        n            = 3'd1;
        kept         = 1'b1;
        case (mode_reg)
            MODE_LATIN1:
            begin
                fire = 1'b1;
                cp   = {13'd0, b};
            end
            MODE_UTF16:
            begin
                if (remain_reg == 2'd0)
                begin
                    if (is_low)
                    begin
                        fire = 1'b1;
                        st   = ST_MALFORMED;
                        kept = 1'b0;
                    end
                    else if (is_high)
                    begin
                        partial_next = {5'd0, unit};
                        remain_next  = 2'd1;
                        seen_next    = 3'd1;
                        len_next     = 3'd2;
                    end
                    else
                    begin
                        fire = 1'b1;
                        cp   = {5'd0, unit};
                    end
                end
                else
                begin
                    fire = 1'b1;
                    n    = 3'd2;
                    if (is_low)
                    begin
                        cp = pair_code;
                    end
                    else
                    begin
                        st   = ST_MALFORMED;
                        kept = 1'b0;
                    end
                end
            end
            MODE_UTF8:
            begin
                if (remain_reg == 2'd0)
                begin
                    seen_next  = 3'd1;
                    cfail_next = 1'b0;
                    if (!b[7])
                    begin
                        fire      = 1'b1;
                        cp        = {13'd0, b};
                        seen_next = seen_reg;
                        cfail_next = cfail_reg;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        partial_next = {16'd0, b[4:0]};
                        remain_next  = 2'd1;
                        len_next     = 3'd2;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        partial_next = {17'd0, b[3:0]};
                        remain_next  = 2'd2;
                        len_next     = 3'd3;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        partial_next = {18'd0, b[2:0]};
                        remain_next  = 2'd3;
                        len_next     = 3'd4;
                    end
                    else
                    begin
                        // stray trail byte or lead byte above four units
                        fire       = 1'b1;
                        st         = ST_MALFORMED;
                        seen_next  = seen_reg;
                        cfail_next = cfail_reg;
                    end
                end
                else
                begin
                    seen_next    = seen_reg + 3'd1;
                    cfail_next   = cfail_reg || (b[7:6] != 2'b10);
                    partial_next = shifted;
                    remain_next  = remain_reg - 2'd1;
                    n            = seen_next;
                    kept         = 1'b0;
                    if (remain_next != 2'd0)
                    begin
                        if (b == 8'd0)
                        begin
                            fire = 1'b1;
                            st   = ST_CUT;
                        end
                    end
                    else
                    begin
                        fire = 1'b1;
                        if (cfail_next)
                        begin
                            st = (b != 8'd0) ? ST_MALFORMED : ST_CUT;
                        end
                        else if (shifted < minimum || shifted > CODE_MAX ||
                                 shifted inside {[21'h00D800:21'h00DFFF]})
                        begin
                            st = ST_MALFORMED;
                        end
                        else
                        begin
                            cp   = shifted;
                            kept = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // unused mode: unit dropped, sequence cleared here
                partial_next = '0;
                remain_next  = '0;
                seen_next    = '0;
                len_next     = '0;
                cfail_next   = 1'b0;
            end
        endcase
        if (fire)
        begin
            partial_next = '0;
            remain_next  = '0;
            seen_next    = '0;
            len_next     = '0;
            cfail_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            partial_reg <= '0;
            remain_reg  <= '0;
            seen_reg    <= '0;
            len_reg     <= '0;
            cfail_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            mode_reg    <= cfg_mode;
            partial_reg <= '0;
            remain_reg  <= '0;
            seen_reg    <= '0;
            len_reg     <= '0;
            cfail_reg   <= 1'b0;
        end
        else if (step)
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            seen_reg    <= seen_next;
            len_reg     <= len_next;
            cfail_reg   <= cfail_next;
        end
    end

    assign res_fire           = fire;
    assign res.code_point     = (st == ST_VALID) ? cp : '0;
    assign res.status         = st;
    assign res.units_examined = n;
    assign res.units_kept     = kept;

endmodule
`default_nettype wire

FILE: hdl/ucud_out_reg.sv
// result register: holds one result beat until the sink takes it
`default_nettype none
module ucud_out_reg
    import ucud_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire result_t        res,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic                free,
    output logic [CodeW-1:0]    code_point,
    output logic [1:0]          status,
    output logic [CountW-1:0]   units_examined,
    output logic                units_kept
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = valid_reg;
    assign code_point     = res_reg.code_point;
    assign status         = res_reg.status;
    assign units_examined = res_reg.units_examined;
    assign units_kept     = res_reg.units_kept;

endmodule
`default_nettype wire

FILE: hdl/unicode_code_unit_decoder.sv
// top level of the latin-1 / utf-16 / utf-8 code unit decoder
//
// Takes one code unit beat per cycle while in_stall is low and decodes it under
// encoding_mode (0 latin-1, 1 utf-16, 2 utf-8; reset 2). A unit enters an input
// register, is decoded in one pass against the sequence state and lands in a
// result register, from which a unit's result, if it causes one, appears on the
// result port. Sustained rate is one unit per cycle while out_stall is low,
// set by the single decode pass between the two registers; while a result
// waits under out_stall, the input register holds its unit and in_stall is
// high in that same cycle. Units that finish a character (or an attempt)
// give one result beat; leading units of a multi-unit sequence give none.
// Writing encoding_mode drops any partial sequence; write it only with no
// beat in flight.
`default_nettype none
module unicode_code_unit_decoder
    import ucud_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [UnitW-1:0]   code_unit,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [CodeW-1:0]        code_point,
    output logic [1:0]              status,
    output logic [CountW-1:0]       units_examined,
    output logic                    units_kept,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         encoding_mode
);

    logic             unit_valid;
    logic [UnitW-1:0] unit_data;
    logic             out_free;
    logic             advance;
    logic             res_fire;
    result_t          res;

    assign advance   = unit_valid && out_free;
    assign cfg_ready = !unit_valid;

    ucud_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .advance    (advance),
        .unit_valid (unit_valid),
        .unit_data  (unit_data)
    );

    ucud_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_mode  (encoding_mode),
        .step      (advance),
        .unit      (unit_data),
        .res_fire  (res_fire),
        .res       (res)
    );

    ucud_out_reg u_out_reg (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (advance && res_fire),
        .res            (res),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .free           (out_free),
        .code_point     (code_point),
        .status         (status),
        .units_examined (units_examined),
        .units_kept     (units_kept)
    );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the latin-1 / utf-16 / utf-8 code unit decoder
module testbench;
    import ucud_pkg::*;

    // predicts decoded characters and checks them against the result beats
    class char_tracker;
        logic [1:0]       mode;
        logic [CodeW-1:0] partial;
        logic [1:0]       remaining;
        logic [2:0]       seen;
        logic [2:0]       seq_len;
        logic             trail_bad;
        result_t          pending[$];
        int               errors;
        int               checked;

        function new();
            mode = MODE_RESET;
            errors = 0;
            checked = 0;
            clear();
        endfunction

        function void clear();
            partial = '0;
            remaining = '0;
            seen = '0;
            seq_len = '0;
            trail_bad = 1'b0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
            clear();
        endfunction

        function void finish_char(logic [CodeW-1:0] cp, status_t st, logic [2:0] n,
                                  logic kept);
            result_t r;
            r.code_point = (st == ST_VALID) ? cp : '0;
            r.status = st;
            r.units_examined = n;
            r.units_kept = kept;
            pending.push_back(r);
            clear();
        endfunction

        function void note_unit(logic [UnitW-1:0] u);
            logic [7:0]       b;
            logic [4:0]       k;
            logic             is_low;
            logic             is_high;
            logic [CodeW-1:0] floor_cp;
            b = u[7:0];
            k = b[7:3];
            is_low = (u >= 16'hDC00) && (u <= 16'hDFFF);
            is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
            case (mode)
                MODE_LATIN1: finish_char(CodeW'(b), ST_VALID, 3'd1, 1'b1);
                MODE_UTF16:
                begin
                    if (remaining == 0)
                    begin
                        if (is_low)
                            finish_char('0, ST_MALFORMED, 3'd1, 1'b0);
                        else if (is_high)
                        begin
                            partial = CodeW'(u);
                            remaining = 2'd1;
                            seen = 3'd1;
                            seq_len = 3'd2;
                        end
                        else
                            finish_char(CodeW'(u), ST_VALID, 3'd1, 1'b1);
                    end
                    else if (!is_low)
                        finish_char('0, ST_MALFORMED, 3'd2, 1'b0);
                    else
                        finish_char(SUPPLEMENTARY + {partial[9:0], u[9:0]}, ST_VALID,
                                    3'd2, 1'b1);
                end
                MODE_UTF8:
                begin
                    if (remaining == 0)
                    begin
                        if (k < 5'd16)
                            finish_char(CodeW'(b), ST_VALID, 3'd1, 1'b1);
                        else if (k >= 5'd24 && k <= 5'd30)
                        begin
                            if (k <= 5'd27)
                            begin
                                partial = CodeW'(b[4:0]);
                                remaining = 2'd1;
                                seq_len = 3'd2;
                            end
                            else if (k <= 5'd29)
                            begin
                                partial = CodeW'(b[3:0]);
                                remaining = 2'd2;
                                seq_len = 3'd3;
                            end
                            else
                            begin
                                partial = CodeW'(b[2:0]);
                                remaining = 2'd3;
                                seq_len = 3'd4;
                            end
                            seen = 3'd1;
                            trail_bad = 1'b0;
                        end
                        else
                            finish_char('0, ST_MALFORMED, 3'd1, 1'b1);
                    end
                    else
                    begin
                        seen = seen + 3'd1;
                        if (b[7:6] != 2'b10)
                            trail_bad = 1'b1;
                        partial = {partial[CodeW-7:0], b[5:0]};
                        remaining = remaining - 2'd1;
                        if (remaining != 0)
                        begin
                            // zero trail byte ends the attempt early
                            if (b == 8'h00)
                                finish_char('0, ST_CUT, seen, 1'b0);
                        end
                        else if (trail_bad)
                            finish_char('0, (b != 8'h00) ? ST_MALFORMED : ST_CUT, seen,
                                        1'b0);
                        else
                        begin
                            floor_cp = (seq_len == 3'd2) ? 21'h80 :
                                       (seq_len == 3'd3) ? 21'h800 : 21'h10000;
                            if (partial < floor_cp || partial > CODE_MAX ||
                                (partial >= 21'hD800 && partial <= 21'hDFFF))
                                finish_char('0, ST_MALFORMED, seen, 1'b0);
                            else
                                finish_char(partial, ST_VALID, seen, 1'b1);
                        end
                    end
                end
                default: clear();
            endcase
        endfunction

        function void report(string what, int expv, int gotv);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what,
                         expv, gotv);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result beat, code_point %0h status %0d",
                             $time, got.code_point, got.status);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.code_point !== want.code_point)
                report("code_point", want.code_point, got.code_point);
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.units_examined !== want.units_examined)
                report("units_examined", want.units_examined, got.units_examined);
            if (got.units_kept !== want.units_kept)
                report("units_kept", want.units_kept, got.units_kept);
        endfunction
    endclass

    localparam int IdleLimit = 1000;

    localparam logic [UnitW-1:0] UTF8_DIRECTED [22] = '{
        16'h0000, 16'hA5C3, 16'h00A9,              // zero, two-byte with junk upper bits
        16'h00C0, 16'h0080,                        // overlong
        16'h00E2, 16'h0082, 16'h00AC,              // three-byte
        16'h00ED, 16'h00A0, 16'h0080,              // encoded surrogate
        16'h00F4, 16'h0090, 16'h0080, 16'h0080,    // above the last code point
        16'h0080, 16'h00FF,                        // bad leads
        16'h00E2, 16'h0000,                        // zero trail before the end
        16'h00E2, 16'h0041, 16'h0082               // bad trail carried to full length
    };
    localparam logic [UnitW-1:0] UTF16_DIRECTED [9] = '{
        16'hDC00, 16'hDBFF, 16'hDFFF, 16'hD800, 16'h0041,
        16'hD800, 16'h0000, 16'hFFFE, 16'hFFFF
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [UnitW-1:0]   code_unit = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CodeW-1:0]   code_point;
    logic [1:0]         status;
    logic [CountW-1:0]  units_examined;
    logic               units_kept;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         encoding_mode = MODE_RESET;

    char_tracker        board = new();
    bit                 quiet = 1'b0;
    int                 units_sent = 0;
    int                 mode_writes = 0;
    int                 idle_cycles = 0;

    unicode_code_unit_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .code_unit      (code_unit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_point     (code_point),
        .status         (status),
        .units_examined (units_examined),
        .units_kept     (units_kept),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .encoding_mode  (encoding_mode)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // beat monitors and watchdog
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_unit(code_unit);
            if (out_valid && !out_stall)
            begin
                got.code_point = code_point;
                got.status = status_t'(status);
                got.units_examined = units_examined;
                got.units_kept = units_kept;
                board.check_result(got);
            end
            if (cfg_valid && cfg_ready)
                board.set_mode(encoding_mode);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, IdleLimit);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side stalls in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && !quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_unit(input logic [UnitW-1:0] u);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        code_unit <= u;
        do
            @(posedge clk);
        while (in_stall);
        units_sent++;
    endtask

    // hold off the sender until every expected character is back
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_valid <= 1'b1;
        encoding_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    task automatic send_utf8_char();
        logic [7:0]       seq [4];
        logic [7:0]       junk;
        logic [CodeW-1:0] cp;
        int               kind;
        int               len;
        int               pos;
        kind = $urandom_range(0, 9);
        len = $urandom_range(1, 4);
        case (len)
            1: cp = CodeW'($urandom_range(0, 'h7F));
            2: cp = CodeW'($urandom_range(0, 'h7FF));
            3: cp = CodeW'($urandom_range(0, 'hFFFF));
            default:
                cp = ($urandom_range(0, 3) == 0) ? CodeW'($urandom_range(0, 'h1FFFFF)) :
                     CodeW'($urandom_range('h10000, 'h10FFFF));
        endcase
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        // corrupt a trail byte, send a stray byte, or cut the sequence short
        if (kind >= 6 && kind <= 7 && len > 1)
            seq[$urandom_range(1, len - 1)] = ($urandom_range(0, 2) == 0) ? 8'h00 :
                                              8'($urandom_range(0, 255));
        else if (kind == 8)
        begin
            len = 1;
            seq[0] = 8'($urandom_range(0, 255));
        end
        else if (kind == 9 && len > 1)
            len = $urandom_range(1, len - 1);
        for (pos = 0; pos < len; pos++)
        begin
            junk = 8'($urandom_range(0, 255));
            send_unit({junk, seq[pos]});
        end
    endtask

    task automatic send_utf16_char();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind <= 11)
            send_unit(UnitW'($urandom_range(0, 'hFFFF)));
        else if (kind <= 16)
        begin
            send_unit(16'hD800 | UnitW'($urandom_range(0, 'h3FF)));
            send_unit(16'hDC00 | UnitW'($urandom_range(0, 'h3FF)));
        end
        else if (kind == 17)
            send_unit(16'hDC00 | UnitW'($urandom_range(0, 'h3FF)));
        else
        begin
            send_unit(16'hD800 | UnitW'($urandom_range(0, 'h3FF)));
            send_unit((kind == 18) ? UnitW'($urandom_range(0, 'hDBFF)) : 16'h0000);
        end
    endtask

    task automatic run_random(input logic [1:0] m, input int count);
        int stop_at;
        stop_at = units_sent + count;
        while (units_sent < stop_at)
        begin
            if (m == MODE_UTF8)
                send_utf8_char();
            else if (m == MODE_UTF16)
                send_utf16_char();
            else
                send_unit(UnitW'($urandom_range(0, 'hFFFF)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // utf-8 after reset, then leave a four-byte sequence half done
        foreach (UTF8_DIRECTED[i])
            send_unit(UTF8_DIRECTED[i]);
        send_unit(16'h00F0);
        send_unit(16'h009F);
        settle();
        write_mode(MODE_UTF8);
        run_random(MODE_UTF8, 500);
        send_unit(16'h00E2);
        settle();

        write_mode(MODE_UTF16);
        foreach (UTF16_DIRECTED[i])
            send_unit(UTF16_DIRECTED[i]);
        run_random(MODE_UTF16, 350);
        send_unit(16'hD801);
        settle();

        write_mode(MODE_LATIN1);
        send_unit(16'hFFFF);
        send_unit(16'h0080);
        run_random(MODE_LATIN1, 200);
        settle();

        // reserved mode: units are dropped and nothing comes back
        write_mode(2'd3);
        run_random(2'd3, 30);
        settle();

        write_mode(MODE_UTF16);
        run_random(MODE_UTF16, 100);
        settle();

        write_mode(MODE_UTF8);
        run_random(MODE_UTF8, 150);
        settle();

        write_mode(MODE_UTF8);
        quiet = 1'b1;
        run_random(MODE_UTF8, 150);

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.pending.size() != 0)
        begin
            board.errors += board.pending.size();
            $display("%0t: %0d expected characters never arrived", $time,
                     board.pending.size());
        end
        $display("sent %0d code units over %0d encoding_mode writes (latin-1, utf-16,",
                 units_sent, mode_writes);
        $display("utf-8, reserved), %0d result beats checked, %0d errors",
                 board.checked, board.errors);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
